>>> hw/rtl/ic3_pkg.sv
// Shared types and constants of the 3x3 convolution block.
`default_nettype none
package ic3_pkg;
    localparam int MAX_LINE_PIXELS_DEF = 2048;
    localparam int LANE_COUNT_DEF = 3;
    localparam int MAX_ROWS = 2048;
    localparam int COORD_W = 13;
    localparam int QDEPTH = 4;
    localparam int CFG_W = 48;
    localparam int PIX_W = 24;

    localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_PRESERVE = 3'd3;
    localparam logic [2:0] REG_KERNEL_TOP = 3'd4;
    localparam logic [2:0] REG_KERNEL_MID = 3'd5;
    localparam logic [2:0] REG_KERNEL_BOT = 3'd6;

    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] win;
        logic [3:0]                 mask;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
        logic [COORD_W-1:0]         wm1;
        logic [COORD_W-1:0]         hm1;
    } ic3_job_t;
endpackage
`default_nettype wire

>>> hw/rtl/ic3_queue.sv
// Short job queue between the pixel front end and the convolution back end.
`default_nettype none
module ic3_queue
    import ic3_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire ic3_job_t push_data,
    output logic          full,
    input  wire logic     pop,
    output ic3_job_t      head,
    output logic          empty
);
    localparam int PW = $clog2(QDEPTH);
    localparam int CNTW = $clog2(QDEPTH + 1);

    ic3_job_t         store_reg [QDEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    assign full  = (count_reg == CNTW'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PW'((int'(wr_ptr_reg) + 1) % QDEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= PW'((int'(rd_ptr_reg) + 1) % QDEPTH);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/ic3_front.sv
// Front end: takes pixels, keeps the line stores and the window, and queues jobs.
`default_nettype none
module ic3_front
    import ic3_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pixel_valid,
    output logic             pixel_ready,
    input  wire logic [7:0]  pixel_ch0,
    input  wire logic [7:0]  pixel_ch1,
    input  wire logic [7:0]  pixel_ch2,
    input  wire logic [11:0] frame_width,
    input  wire logic [11:0] frame_height,
    input  wire logic        full,
    output logic             push,
    output ic3_job_t         job
);
    localparam int AW = $clog2(MAX_LINE_PIXELS);
    localparam logic [13:0] WMAX = 14'(MAX_LINE_PIXELS);
    localparam logic [13:0] HMAX = 14'(MAX_ROWS);

    logic [PIX_W-1:0] mem_up [MAX_LINE_PIXELS];
    logic [PIX_W-1:0] mem_lo [MAX_LINE_PIXELS];

    logic [AW-1:0]    col_reg;
    logic [10:0]      row_reg;
    logic             f1_valid_reg;
    logic [AW-1:0]    f1_c_reg;
    logic [10:0]      f1_r_reg;
    logic [PIX_W-1:0] f1_pix_reg;
    logic [3:0]       f1_mask_reg;
    logic [AW-1:0]    f1_wm1_reg;
    logic [10:0]      f1_hm1_reg;
    logic [PIX_W-1:0] up_rd_reg;
    logic [PIX_W-1:0] lo_rd_reg;
    logic             byp_reg;
    logic [PIX_W-1:0] byp_up_reg;
    logic [PIX_W-1:0] byp_lo_reg;
    logic [2:0][2:0][PIX_W-1:0] win_reg;
    logic [2:0][2:0][PIX_W-1:0] win_next;

    logic [13:0]      w_eff;
    logic [13:0]      h_eff;
    logic [AW-1:0]    wm1;
    logic [10:0]      hm1;
    logic [AW-1:0]    c;
    logic [10:0]      r;
    logic             row_end;
    logic             last_row;
    logic [3:0]       mask;
    logic             accept;
    logic [PIX_W-1:0] up_eff;
    logic [PIX_W-1:0] lo_eff;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;

    always_comb
    begin
        w_eff = (frame_width == '0) ? 14'd1 : {2'b00, frame_width};
        if (w_eff > WMAX)
        begin
            w_eff = WMAX;
        end
        h_eff = (frame_height == '0) ? 14'd1 : {2'b00, frame_height};
        if (h_eff > HMAX)
        begin
            h_eff = HMAX;
        end
    end

    assign wm1 = AW'(w_eff - 14'd1);
    assign hm1 = 11'(h_eff - 14'd1);
    // Counters beyond a shrunken frame are pulled back to its last column or row.
    assign c = (col_reg > wm1) ? wm1 : col_reg;
    assign r = (row_reg > hm1) ? hm1 : row_reg;
    assign row_end  = (c == wm1);
    assign last_row = (r == hm1);
    assign mask = {last_row && row_end, last_row && (c != '0),
                   (r != '0) && row_end, (r != '0) && (c != '0)};

    assign push        = f1_valid_reg && !full;
    assign pixel_ready = !f1_valid_reg || push;
    assign accept      = pixel_valid && pixel_ready;

    // A read issued in the same cycle as a write to the same column sees the old
    // entry, so the written data is forwarded instead.
    assign up_eff = byp_reg ? byp_up_reg : up_rd_reg;
    assign lo_eff = byp_reg ? byp_lo_reg : lo_rd_reg;
    assign top = (f1_r_reg >= 11'd2) ? up_eff : '0;
    assign mid = (f1_r_reg >= 11'd1) ? lo_eff : '0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = top;
        win_next[1][2] = mid;
        win_next[2][2] = f1_pix_reg;
    end

    always_comb
    begin
        job.win  = win_next;
        job.mask = f1_mask_reg;
        job.col  = COORD_W'(f1_c_reg);
        job.row  = COORD_W'(f1_r_reg);
        job.wm1  = COORD_W'(f1_wm1_reg);
        job.hm1  = COORD_W'(f1_hm1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_up[f1_c_reg] <= mid;
            mem_lo[f1_c_reg] <= f1_pix_reg;
        end
        if (accept)
        begin
            up_rd_reg   <= mem_up[c];
            lo_rd_reg   <= mem_lo[c];
            byp_up_reg  <= mid;
            byp_lo_reg  <= f1_pix_reg;
            f1_c_reg    <= c;
            f1_r_reg    <= r;
            f1_pix_reg  <= {pixel_ch2, pixel_ch1, pixel_ch0};
            f1_mask_reg <= mask;
            f1_wm1_reg  <= wm1;
            f1_hm1_reg  <= hm1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                byp_reg <= push && (f1_c_reg == c);
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? 11'd0 : r + 11'd1;
                end
                else
                begin
                    col_reg <= c + 1'b1;
                    row_reg <= r;
                end
            end
            if (accept)
            begin
                f1_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                f1_valid_reg <= 1'b0;
            end
            if (push)
            begin
                win_reg <= win_next;
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/ic3_back.sv
// Back end: expands queued jobs into results and runs the multiply-add pipeline.
`default_nettype none
module ic3_back
    import ic3_pkg::*;
#(
    parameter int LANE_COUNT = LANE_COUNT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ic3_job_t          head,
    input  wire logic              empty,
    output logic                   pop,
    input  wire logic [2:0][47:0]  kernel,
    input  wire logic [1:0]        channel_count,
    input  wire logic              preserve_channels,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic signed [31:0]     result_ch0,
    output logic signed [31:0]     result_ch1,
    output logic signed [31:0]     result_ch2,
    output logic                   frame_end
);
    localparam int SW = COORD_W + 2;
    localparam logic signed [SW-1:0] S_ZERO = '0;
    localparam logic signed [SW-1:0] S_ONE = SW'(1);
    localparam logic signed [SW-1:0] S_TWO = SW'(2);
    localparam logic [1:0] LANE_LIM = (LANE_COUNT > 3) ? 2'd3 : 2'(LANE_COUNT);

    // Window slot for a neighbour at pos + k - 1, clamped to the frame edge.
    function automatic logic [1:0] win_idx(input logic [COORD_W-1:0] pos,
                                           input logic [1:0] k,
                                           input logic [COORD_W-1:0] lim,
                                           input logic [COORD_W-1:0] cur);
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] d;
        v = $signed({2'b00, pos}) + $signed({{COORD_W{1'b0}}, k}) - S_ONE;
        if (v < S_ZERO)
        begin
            v = S_ZERO;
        end
        if (v > $signed({2'b00, lim}))
        begin
            v = $signed({2'b00, lim});
        end
        d = v - $signed({2'b00, cur}) + S_TWO;
        if (d < S_ZERO)
        begin
            d = S_ZERO;
        end
        if (d > S_TWO)
        begin
            d = S_TWO;
        end
        return d[1:0];
    endfunction

    logic [3:0]  done_reg;
    logic [3:0]  pending;
    logic [3:0]  sel;
    logic        adv;
    logic        issue;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;

    logic                     s1_valid_reg;
    logic [8:0][PIX_W-1:0]    s1_pix_reg;
    logic [8:0][15:0]         s1_coef_reg;
    logic                     s1_fe_reg;
    logic [8:0][PIX_W-1:0]    pix_sel;
    logic [8:0][15:0]         coef_sel;

    logic                     s2_valid_reg;
    logic signed [24:0]       s2_prod_reg [3][9];
    logic                     s2_fe_reg;

    logic                     s3_valid_reg;
    logic signed [28:0]       s3_sum_reg [3];
    logic signed [28:0]       sum_next [3];
    logic                     s3_fe_reg;

    logic                     s4_valid_reg;
    logic signed [31:0]       res_next [3];
    logic [1:0]               nch;
    logic signed [30:0]       total;

    assign adv     = !s4_valid_reg || result_ready;
    assign pending = empty ? 4'd0 : (head.mask & ~done_reg);
    assign sel     = pending & (~pending + 4'd1);
    assign issue   = adv && (pending != '0);
    // A job that releases nothing leaves at once; otherwise after its last result.
    assign pop = !empty && ((pending == '0) || (issue && ((pending & ~sel) == '0)));

    assign x = (sel[1] || sel[3]) ? head.col : head.col - 1'b1;
    assign y = (sel[0] || sel[1]) ? head.row - 1'b1 : head.row;

    always_comb
    begin
        for (int ky = 0; ky < 3; ky++)
        begin
            for (int kx = 0; kx < 3; kx++)
            begin
                pix_sel[ky * 3 + kx] = head.win[win_idx(y, 2'(ky), head.hm1, head.row)]
                                                [win_idx(x, 2'(kx), head.wm1, head.col)];
                coef_sel[ky * 3 + kx] = kernel[ky][16 * kx +: 16];
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next[ch] = '0;
            for (int i = 0; i < 9; i++)
            begin
                sum_next[ch] = sum_next[ch] + 29'(s2_prod_reg[ch][i]);
            end
        end
    end

    always_comb
    begin
        nch = (channel_count == '0) ? 2'd1 : channel_count;
        if (nch > LANE_LIM)
        begin
            nch = LANE_LIM;
        end
        total = 31'(s3_sum_reg[0]);
        if (nch >= 2'd2)
        begin
            total = total + 31'(s3_sum_reg[1]);
        end
        if (nch >= 2'd3)
        begin
            total = total + 31'(s3_sum_reg[2]);
        end
        if (preserve_channels)
        begin
            res_next[0] = 32'(s3_sum_reg[0]);
            res_next[1] = (nch >= 2'd2) ? 32'(s3_sum_reg[1]) : 32'sd0;
            res_next[2] = (nch >= 2'd3) ? 32'(s3_sum_reg[2]) : 32'sd0;
        end
        else
        begin
            res_next[0] = 32'(total);
            res_next[1] = 32'sd0;
            res_next[2] = 32'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= pix_sel;
            s1_coef_reg <= coef_sel;
            s1_fe_reg   <= (x == head.wm1) && (y == head.hm1);
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    s2_prod_reg[ch][i] <= $signed(s1_coef_reg[i])
                                          * $signed({1'b0, s1_pix_reg[i][8 * ch +: 8]});
                end
                s3_sum_reg[ch] <= sum_next[ch];
            end
            s2_fe_reg  <= s1_fe_reg;
            s3_fe_reg  <= s2_fe_reg;
            result_ch0 <= res_next[0];
            result_ch1 <= res_next[1];
            result_ch2 <= res_next[2];
            frame_end  <= s3_fe_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                done_reg <= '0;
            end
            else if (issue)
            begin
                done_reg <= done_reg | sel;
            end
            if (adv)
            begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign result_valid = s4_valid_reg;
endmodule
`default_nettype wire

>>> hw/rtl/image_convolution_3x3.sv
// Top level of the streaming 3x3 convolution with edge replication.
//
// Pixels enter in raster order on the pixel channel (valid/ready, one transfer
// per pixel, up to three 8-bit channels). Each result leaves on the result
// channel as exact signed sums with 12 fraction bits; frame_end flags the
// result of the frame's last pixel. A result is released once its lower-right
// neighbour has arrived, so the end of a row gives up to two results, and in
// the last row of a frame each pixel gives up to two and the final pixel up to
// four. A releasing pixel passes the line store read register, the job queue
// and the four multiply-add stages, the first of which reads the queue head.
// The back end produces one result per cycle while the receiver takes them, so
// the block takes one pixel per cycle while the queue has room; a job releasing
// several results stays queued until its last is issued, slowing the input.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset sets the kernel to 4096 at the middle row's left tap and 0 elsewhere,
// a 2048 x 2048 frame and three preserved channels, and starts a new frame.
// When the receiver stalls, results wait in the pipeline and jobs in a
// four-entry queue, after which pixel_ready drops.
`default_nettype none
module image_convolution_3x3
    import ic3_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF,
    parameter int LANE_COUNT = LANE_COUNT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              pixel_valid,
    output logic                   pixel_ready,
    input  wire logic [7:0]        pixel_ch0,
    input  wire logic [7:0]        pixel_ch1,
    input  wire logic [7:0]        pixel_ch2,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic signed [31:0]     result_ch0,
    output logic signed [31:0]     result_ch1,
    output logic signed [31:0]     result_ch2,
    output logic                   frame_end
);
    logic [11:0]      frame_width_reg;
    logic [11:0]      frame_height_reg;
    logic [1:0]       channel_count_reg;
    logic             preserve_reg;
    logic [2:0][47:0] kernel_reg;

    logic     q_full;
    logic     q_empty;
    logic     q_push;
    logic     q_pop;
    ic3_job_t q_in;
    ic3_job_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= 12'd2048;
            frame_height_reg  <= 12'd2048;
            channel_count_reg <= 2'd3;
            preserve_reg      <= 1'b1;
            kernel_reg[0]     <= 48'd0;
            kernel_reg[1]     <= 48'd4096;
            kernel_reg[2]     <= 48'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[11:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[11:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[1:0];
                REG_PRESERVE:      preserve_reg      <= cfg_data[0];
                REG_KERNEL_TOP:    kernel_reg[0]     <= cfg_data;
                REG_KERNEL_MID:    kernel_reg[1]     <= cfg_data;
                REG_KERNEL_BOT:    kernel_reg[2]     <= cfg_data;
                default:           ;
            endcase
        end
    end

    ic3_front #(
        .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_ch0    (pixel_ch0),
        .pixel_ch1    (pixel_ch1),
        .pixel_ch2    (pixel_ch2),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .full         (q_full),
        .push         (q_push),
        .job          (q_in)
    );

    ic3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    ic3_back #(
        .LANE_COUNT(LANE_COUNT)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (q_head),
        .empty             (q_empty),
        .pop               (q_pop),
        .kernel            (kernel_reg),
        .channel_count     (channel_count_reg),
        .preserve_channels (preserve_reg),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .result_ch0        (result_ch0),
        .result_ch1        (result_ch1),
        .result_ch2        (result_ch2),
        .frame_end         (frame_end)
    );
endmodule
`default_nettype wire
